@@ rtl/core/cel_pkg.sv @@
// shared constants, types and the log2 mantissa table for the loss accumulator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package cel_pkg;

    // number formats
    localparam int PROB_FRAC_BITS = 31;
    localparam int PROB_W         = 32;
    localparam int ACC_WIDTH      = 40;
    localparam int OUT_W          = 40;
    localparam int LOG_TABLE_BITS = 8;
    localparam int K_W            = $clog2(PROB_W);
    localparam int MANT_W         = 31;
    localparam int FRAC_SH        = MANT_W - LOG_TABLE_BITS;
    localparam int TAB_N          = (1 << LOG_TABLE_BITS) + 1;
    localparam int TAB_W          = 31;
    localparam int NL2_W          = 36;
    localparam int LN2_W          = 28;
    localparam int NLOG_W         = 22;
    localparam int TERM_W         = NLOG_W + PROB_W - PROB_FRAC_BITS;
    localparam int CNT_W          = $clog2(ACC_WIDTH);

    localparam logic [63:0] PONE_64   = 64'd1 << PROB_FRAC_BITS;
    localparam logic [63:0] PFLOOR_64 = (PONE_64 + 64'd5000000) / 64'd10000000;
    localparam logic [PROB_W-1:0] PONE   = PROB_W'(PONE_64);
    localparam logic [PROB_W-1:0] PFLOOR =
        (PFLOOR_64 == 64'd0) ? PROB_W'(1) : PROB_W'(PFLOOR_64);
    localparam logic [LN2_W-1:0] LN2_Q28 = 28'd186065279;
    localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MB_COUNT  = 2'd1;
    localparam int MB_W = 16;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic [PROB_W-1:0] probability;
        logic [PROB_W-1:0] target;
        logic              last;
    } item_t;

    typedef enum logic [1:0] {
        ACC_RUN,
        ACC_DIV,
        ACC_DONE
    } acc_state_t;

    typedef logic [TAB_W-1:0] log_tab_t [TAB_N];

    // log2(1 + i/2^LOG_TABLE_BITS) in Q0.30 by repeated squaring
    function automatic logic [TAB_W-1:0] log2_mant(int unsigned i);
        logic [63:0]      y;
        logic [TAB_W-1:0] r;
        y = (64'(1 << LOG_TABLE_BITS) + 64'(i)) << FRAC_SH;
        r = '0;
        for (int b = 29; b >= 0; b--)
        begin
            y = (y * y) >> 31;
            if (y >= (64'd2 << 31))
            begin
                y    = y >> 1;
                r[b] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic log_tab_t build_log_tab();
        log_tab_t t;
        for (int i = 0; i < TAB_N - 1; i++)
        begin
            t[i] = log2_mant(i);
        end
        t[TAB_N-1] = TAB_W'(1) << 30;
        return t;
    endfunction

    localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

@@ rtl/core/cel_front.sv @@
// front end: accepts items and holds them in a short queue for the back end
// depends on cel_pkg
`timescale 1ns / 1ps

module cel_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  cel_pkg::item_t in_item,
    output logic           q_valid,
    input  logic           q_ready,
    output cel_pkg::item_t q_item
);
    import cel_pkg::*;

    item_t             slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    logic              push, pop;

    // handshake decode
    assign in_stall = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign push     = in_valid && !in_stall;
    assign pop      = q_valid && q_ready;
    assign q_item   = slot_reg[rd_reg];

    // pointer and fill count
    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // item storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= in_item;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (QPTR_W+1)'(QDEPTH))
        else $error("queue fill count beyond depth");
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count missed a push");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (wr_reg == rd_reg))
        else $error("empty queue with pointers apart");

endmodule

@@ rtl/core/cel_neglog.sv @@
// back end pipeline: clamp, normalise, table log2 and scale to the weighted -ln(p) term
// depends on cel_pkg (log table and widths)
`timescale 1ns / 1ps

module cel_neglog (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  cel_pkg::item_t            in_item,
    output logic                      t_valid,
    input  logic                      t_ready,
    output logic [cel_pkg::TERM_W-1:0] t_term,
    output logic                      t_last
);
    import cel_pkg::*;

    logic [6:1] v_reg;
    logic       adv;

    logic [PROB_W-1:0] pc_c, pc1_reg;
    logic [K_W-1:0]    k_c, k1_reg;
    logic [PROB_W-1:0] y1_reg, y2_reg, y3_reg, y4_reg, y5_reg;
    logic [6:1]        last_reg;

    logic [PROB_W-1:0]      shifted_c;
    logic [LOG_TABLE_BITS-1:0] idx_c;
    logic [TAB_W-1:0]       t0_c, t1_c;
    logic [TAB_W-1:0]       t0_2_reg, t0_3_reg, d2_reg;
    logic [FRAC_SH-1:0]     f2_reg;
    logic [K_W-1:0]         sh2_reg, sh3_reg;
    logic [TAB_W+FRAC_SH-1:0] prod3_reg;
    logic [TAB_W-1:0]       lg_c;
    logic [NL2_W-1:0]       nl2_c, nl2_4_reg;
    logic [63:0]            p5_reg, rnd_c;
    logic [NLOG_W-1:0]      nlog_c;
    logic [NLOG_W+PROB_W-1:0] p6_reg;

    assign adv      = !v_reg[6] || t_ready;
    assign in_ready = adv;
    assign t_valid  = v_reg[6];
    assign t_last   = last_reg[6];
    assign t_term   = TERM_W'(p6_reg >> PROB_FRAC_BITS);

    // clamp and leading-one position
    always_comb
    begin
        pc_c = in_item.probability;
        if (pc_c > PONE)
        begin
            pc_c = PONE;
        end
        if (pc_c < PFLOOR)
        begin
            pc_c = PFLOOR;
        end
        k_c = '0;
        for (int i = 0; i < PROB_W; i++)
        begin
            if (pc_c[i])
            begin
                k_c = K_W'(i);
            end
        end
    end

    // mantissa split and table lookup
    always_comb
    begin
        shifted_c = pc1_reg << (K_W'(PROB_W - 1) - k1_reg);
        idx_c     = shifted_c[MANT_W-1 -: LOG_TABLE_BITS];
        t0_c      = LOG_TAB[idx_c];
        t1_c      = LOG_TAB[(LOG_TABLE_BITS+1)'(idx_c) + 1'b1];
    end

    // interpolation, exponent and rounding
    always_comb
    begin
        lg_c   = t0_3_reg + TAB_W'(prod3_reg >> FRAC_SH);
        nl2_c  = (NL2_W'(sh3_reg) << 30) - NL2_W'(lg_c);
        rnd_c  = p5_reg + (64'd1 << 41);
        nlog_c = NLOG_W'(rnd_c >> 42);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[5:1], in_valid};
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pc1_reg   <= pc_c;
            k1_reg    <= k_c;
            y1_reg    <= in_item.target;
            last_reg  <= {last_reg[5:1], in_item.last};
            t0_2_reg  <= t0_c;
            d2_reg    <= t1_c - t0_c;
            f2_reg    <= shifted_c[FRAC_SH-1:0];
            sh2_reg   <= K_W'(PROB_FRAC_BITS) - k1_reg;
            y2_reg    <= y1_reg;
            prod3_reg <= d2_reg * f2_reg;
            t0_3_reg  <= t0_2_reg;
            sh3_reg   <= sh2_reg;
            y3_reg    <= y2_reg;
            nl2_4_reg <= nl2_c;
            y4_reg    <= y3_reg;
            p5_reg    <= 64'(nl2_4_reg) * 64'(LN2_Q28);
            y5_reg    <= y4_reg;
            p6_reg    <= nlog_c * y5_reg;
        end
    end

    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[6] && !t_ready) |=> v_reg[6] && $stable(p6_reg))
        else $error("finished term lost while held");
    a_norm: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[1] |-> pc1_reg[k1_reg] && (k1_reg <= K_W'(PROB_FRAC_BITS)))
        else $error("leading-one position wrong");
    a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[2] |-> sh2_reg <= K_W'(PROB_FRAC_BITS - 7))
        else $error("exponent beyond floor range");

endmodule

@@ rtl/core/cel_accum.sv @@
// back end tail: saturating sum, mean divider and result register
// depends on cel_pkg (state type and widths)
`timescale 1ns / 1ps

module cel_accum (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          t_valid,
    output logic                          t_ready,
    input  logic [cel_pkg::TERM_W-1:0]    t_term,
    input  logic                          t_last,
    input  logic                          mean_mode,
    input  logic [cel_pkg::MB_W-1:0]      mb_count,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cel_pkg::OUT_W-1:0]     loss_value,
    output logic                          saturated
);
    import cel_pkg::*;

    acc_state_t state_reg, state_next;
    logic [ACC_WIDTH-1:0] sum_reg, sum_next;
    logic                 clip_reg, clip_next;
    logic [ACC_WIDTH-1:0] quo_reg, quo_next;
    logic [MB_W-1:0]      rem_reg, rem_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 satp_reg, satp_next;
    logic                 ov_reg, ov_next;
    logic [OUT_W-1:0]     loss_reg, loss_next;
    logic                 sat_reg, sat_next;

    logic [ACC_WIDTH:0]   sum_add;
    logic [ACC_WIDTH-1:0] sum_new;
    logic                 clip_new;
    logic                 out_free;
    logic                 take;
    logic [MB_W-1:0]      divisor;
    logic [MB_W:0]        rem_sh;
    logic                 qbit;

    assign out_valid  = ov_reg;
    assign loss_value = loss_reg;
    assign saturated  = sat_reg;

    // saturating add and divider step
    always_comb
    begin
        sum_add  = {1'b0, sum_reg} + (ACC_WIDTH+1)'(t_term);
        sum_new  = sum_add[ACC_WIDTH] ? ACC_MAX : sum_add[ACC_WIDTH-1:0];
        clip_new = clip_reg || sum_add[ACC_WIDTH];
        out_free = !ov_reg || !out_stall;
        divisor  = (mb_count == '0) ? MB_W'(1) : mb_count;
        rem_sh   = {rem_reg, quo_reg[ACC_WIDTH-1]};
        qbit     = (rem_sh >= {1'b0, divisor});
    end

    // control and next values
    always_comb
    begin
        state_next = state_reg;
        sum_next   = sum_reg;
        clip_next  = clip_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        satp_next  = satp_reg;
        loss_next  = loss_reg;
        sat_next   = sat_reg;
        ov_next    = ov_reg && out_stall;
        t_ready    = 1'b0;
        take       = 1'b0;
        unique case (state_reg)
            ACC_RUN:
            begin
                t_ready = !t_last || mean_mode || out_free;
                take    = t_valid && t_ready;
                if (take && !t_last)
                begin
                    sum_next  = sum_new;
                    clip_next = clip_new;
                end
                else if (take)
                begin
                    sum_next  = '0;
                    clip_next = 1'b0;
                    if (mean_mode)
                    begin
                        quo_next   = sum_new;
                        rem_next   = '0;
                        cnt_next   = '0;
                        satp_next  = clip_new;
                        state_next = ACC_DIV;
                    end
                    else
                    begin
                        ov_next   = 1'b1;
                        loss_next = OUT_W'(sum_new);
                        sat_next  = clip_new;
                    end
                end
            end
            ACC_DIV:
            begin
                rem_next = qbit ? MB_W'(rem_sh - {1'b0, divisor}) : rem_sh[MB_W-1:0];
                quo_next = {quo_reg[ACC_WIDTH-2:0], qbit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ACC_WIDTH - 1))
                begin
                    state_next = ACC_DONE;
                end
            end
            ACC_DONE:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    loss_next  = OUT_W'(quo_reg);
                    sat_next   = satp_reg;
                    state_next = ACC_RUN;
                end
            end
            default:
            begin
                state_next = ACC_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ACC_RUN;
            sum_reg   <= '0;
            clip_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            clip_reg  <= clip_next;
            ov_reg    <= ov_next;
            cnt_reg   <= cnt_next;
        end
    end

    // divider and result payload
    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        satp_reg <= satp_next;
        loss_reg <= loss_next;
        sat_reg  <= sat_next;
    end

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (take && t_last) |=> (sum_reg == '0) && !clip_reg)
        else $error("sum not cleared after last item");
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ACC_DIV) |-> cnt_reg < CNT_W'(ACC_WIDTH))
        else $error("divider ran past its length");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> $stable(loss_reg) && $stable(sat_reg))
        else $error("waiting result overwritten");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ACC_RUN) |-> !t_ready)
        else $error("term taken while dividing");

endmodule

@@ rtl/core/cross_entropy_loss_accumulator_core.sv @@
// Cross-entropy loss accumulator, top level.
// Input channel (in_valid / in_stall): one probability and target pair per item,
// both unsigned Q1.31, last marks the final element of a tensor. Items queue in a
// four-entry buffer, so the source sees stall only when that buffer is full.
// Back end: a six-stage pipeline forms the weighted -ln(p) term, then a saturating
// 40-bit sum. Throughput is one item per cycle while no result is being formed.
// Output channel (out_valid / out_stall): one item per tensor, on its last element,
// carrying the Q24.16 loss and the saturated flag. In mean mode a restoring divider,
// one quotient bit per cycle, forms the mean after the last item, during which the
// back end holds its terms.
// A stalled result waits in the output register; further items still queue and the
// pipeline keeps flowing until another last item needs that register.
// Configuration (cfg_valid / cfg_ready, always ready): index 0 mean_mode,
// index 1 microbatch_count; other indexes are ignored. Write only while idle.
// Reset clears the sum, the queue, the pipeline and sets mean_mode 0, count 1.
`timescale 1ns / 1ps

module cross_entropy_loss_accumulator_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [cel_pkg::PROB_W-1:0]       probability,
    input  logic [cel_pkg::PROB_W-1:0]       target,
    input  logic                             last,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [cel_pkg::OUT_W-1:0]        loss_value,
    output logic                             saturated,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cel_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cel_pkg::MB_W-1:0]         cfg_data
);
    import cel_pkg::*;

    logic            mean_reg;
    logic [MB_W-1:0] mb_reg;
    item_t           in_item, q_item;
    logic            q_valid, q_ready;
    logic            t_valid, t_ready, t_last;
    logic [TERM_W-1:0] t_term;

    assign cfg_ready = 1'b1;
    assign in_item   = '{probability: probability, target: target, last: last};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg <= 1'b0;
            mb_reg   <= MB_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_MEAN_MODE)
            begin
                mean_reg <= cfg_data[0];
            end
            else if (cfg_index == REG_MB_COUNT)
            begin
                mb_reg <= cfg_data;
            end
        end
    end

    cel_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    cel_neglog u_neglog (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_item  (q_item),
        .t_valid  (t_valid),
        .t_ready  (t_ready),
        .t_term   (t_term),
        .t_last   (t_last)
    );

    cel_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .t_valid    (t_valid),
        .t_ready    (t_ready),
        .t_term     (t_term),
        .t_last     (t_last),
        .mean_mode  (mean_reg),
        .mb_count   (mb_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .loss_value (loss_value),
        .saturated  (saturated)
    );

endmodule

@@ tb/sv/cross_entropy_loss_accumulator_core_test.sv @@
// self-checking testbench for cross_entropy_loss_accumulator_core
// needs cel_pkg and the core rtl; a built-in loss predictor, or the typed expectation of a row, checks every result
`timescale 1ns / 1ps

module cross_entropy_loss_accumulator_core_test;

    import cel_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [63:0] SUM_LIMIT = (64'd1 << ACC_WIDTH) - 64'd1;
    localparam logic [63:0] OUT_LIMIT = (64'd1 << OUT_W) - 64'd1;
    localparam int SETTLE_CYCLES = 80;
    localparam int FLOOR_ITEMS = 136;

    typedef struct packed {
        logic [OUT_W-1:0] loss;
        logic             sat;
    } loss_item_t;

    typedef struct {
        logic [PROB_W-1:0] prob;
        logic [PROB_W-1:0] tgt;
        logic              lst;
        logic              typed;
        logic [OUT_W-1:0]  loss;
        logic              sat;
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [PROB_W-1:0] probability;
    logic [PROB_W-1:0] target;
    logic last;
    logic out_valid;
    logic out_stall;
    logic [OUT_W-1:0] loss_value;
    logic saturated;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MB_W-1:0] cfg_data;

    // typed expectation travelling with the item
    logic             row_typed;
    logic [OUT_W-1:0] row_loss;
    logic             row_sat;

    logic idle_on;
    logic hold_on;
    event hold_ev;
    int   err_count;

    // predictor state
    logic [63:0]  mant_log [TAB_N];
    logic         pm_mean;
    logic [15:0]  pm_count;
    logic [63:0]  pm_sum;
    logic         pm_clip;
    loss_item_t   loss_expect_q [$];

    cross_entropy_loss_accumulator_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .probability(probability),
        .target     (target),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .loss_value (loss_value),
        .saturated  (saturated),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // log2 mantissa entry by repeated squaring, q0.30
    function automatic logic [63:0] mant_entry(int unsigned i);
        logic [63:0] y;
        logic [63:0] r;
        y = (64'd256 + 64'(i)) << 23;
        r = '0;
        for (int b = 29; b >= 0; b--)
        begin
            y = (y * y) >> 31;
            if (y >= (64'd2 << 31))
            begin
                y = y >> 1;
                r[b] = 1'b1;
            end
        end
        return r;
    endfunction

    // -ln(p) in q5.16
    function automatic logic [63:0] neg_ln(logic [PROB_W-1:0] p);
        logic [63:0] pc;
        logic [63:0] m;
        logic [63:0] f;
        logic [63:0] lg;
        logic [63:0] nl2;
        int unsigned k;
        int unsigned idx;
        pc = 64'(p);
        if (pc > PONE_64)
            pc = PONE_64;
        if (pc < 64'(PFLOOR))
            pc = 64'(PFLOOR);
        k = 0;
        for (int b = 0; b < 32; b++)
        begin
            if (pc[b])
                k = b;
        end
        m = (pc << (31 - k)) & 64'h7FFF_FFFF;
        idx = int'(m >> 23);
        f = m & 64'h7F_FFFF;
        lg = mant_log[idx] + (((mant_log[idx + 1] - mant_log[idx]) * f) >> 23);
        nl2 = (64'(PROB_FRAC_BITS - k) << 30) - lg;
        return (nl2 * 64'(LN2_Q28) + (64'd1 << 41)) >> 42;
    endfunction

    // accumulate one item, queue a loss on the last element
    task automatic accumulate(logic [PROB_W-1:0] p, logic [PROB_W-1:0] y, logic l,
                              logic typed, logic [OUT_W-1:0] tl, logic ts);
        logic [63:0] term;
        logic [63:0] res;
        loss_item_t  e;
        term = (neg_ln(p) * 64'(y)) >> PROB_FRAC_BITS;
        if (term > SUM_LIMIT - pm_sum)
        begin
            pm_sum = SUM_LIMIT;
            pm_clip = 1'b1;
        end
        else
            pm_sum = pm_sum + term;
        if (l)
        begin
            res = pm_sum;
            if (pm_mean)
                res = res / ((pm_count == 16'd0) ? 64'd1 : 64'(pm_count));
            e.sat = pm_clip;
            if (res > OUT_LIMIT)
            begin
                res = OUT_LIMIT;
                e.sat = 1'b1;
            end
            e.loss = res[OUT_W-1:0];
            if (typed)
            begin
                e.loss = tl;
                e.sat = ts;
            end
            loss_expect_q.push_back(e);
            pm_sum = '0;
            pm_clip = 1'b0;
        end
    endtask

    // input and configuration monitors
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            accumulate(probability, target, last, row_typed, row_loss, row_sat);
        if (rst_n && cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_MEAN_MODE)
                pm_mean = cfg_data[0];
            else if (cfg_index == REG_MB_COUNT)
                pm_count = cfg_data;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        loss_item_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (loss_expect_q.size() == 0)
            begin
                $display("%t unexpected loss item: loss %0d saturated %0d",
                         $realtime, loss_value, saturated);
                err_count++;
            end
            else
            begin
                e = loss_expect_q.pop_front();
                if (loss_value !== e.loss)
                begin
                    $display("%t loss_value expected %0d actual %0d",
                             $realtime, e.loss, loss_value);
                    err_count++;
                end
                if (saturated !== e.sat)
                begin
                    $display("%t saturated expected %0d actual %0d",
                             $realtime, e.sat, saturated);
                    err_count++;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always
    begin
        @(hold_ev);
        hold_on = 1'b1;
        repeat (300) @(negedge clk);
        hold_on = 1'b0;
    end

    // receiver stall
    always @(negedge clk)
    begin
        out_stall = hold_on || (idle_on && ($urandom % 100 < 8));
    end

    // offer one item and wait for it to be taken
    task automatic offer(row_t r);
        if (idle_on)
        begin
            while ($urandom % 100 < 8)
            begin
                in_valid = 1'b0;
                @(negedge clk);
            end
        end
        in_valid = 1'b1;
        probability = r.prob;
        target = r.tgt;
        last = r.lst;
        row_typed = r.typed;
        row_loss = r.loss;
        row_sat = r.sat;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic quiesce();
        in_valid = 1'b0;
        row_typed = 1'b0;
        wait (loss_expect_q.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MB_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [PROB_W-1:0] rand_prob();
        case ($urandom % 4)
            0: return $urandom;
            1: return $urandom_range(0, PONE);
            2: return $urandom_range(0, 4000);
            default: return PONE - $urandom_range(0, 1000);
        endcase
    endfunction

    function automatic row_t rand_row();
        row_t r;
        r.prob = rand_prob();
        case ($urandom % 3)
            0: r.tgt = $urandom;
            1: r.tgt = $urandom_range(0, PONE);
            default: r.tgt = ($urandom % 2) ? '0 : PONE;
        endcase
        r.lst = ($urandom % 8 == 0);
        r.typed = 1'b0;
        r.loss = '0;
        r.sat = 1'b0;
        return r;
    endfunction

    task automatic random_phase(int n, logic squeeze);
        row_t r;
        for (int i = 0; i < n; i++)
        begin
            if (squeeze && i == 40)
                -> hold_ev;
            if (squeeze && i == 120)
            begin
                in_valid = 1'b0;
                wait (loss_expect_q.size() == 0);
                @(negedge clk);
            end
            r = rand_row();
            if (i == n - 1)
                r.lst = 1'b1;
            offer(r);
        end
        quiesce();
    endtask

    // directed rows: extremes, clamps, floor, zero target
    row_t directed [] = '{
        '{PONE,          PONE,          1'b1, 1'b1, 40'd0, 1'b0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 40'd0, 1'b0},
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 40'd0, 1'b0},
        '{32'h0000_0000, PONE,          1'b0, 1'b0, 40'd0, 1'b0},
        '{32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 1'b0, 40'd0, 1'b0},
        '{PFLOOR,        PONE,          1'b1, 1'b0, 40'd0, 1'b0},
        '{PFLOOR - 1,    PONE,          1'b0, 1'b0, 40'd0, 1'b0},
        '{PFLOOR + 1,    32'h4000_0000, 1'b1, 1'b0, 40'd0, 1'b0},
        '{32'h4000_0000, PONE,          1'b1, 1'b0, 40'd0, 1'b0},
        '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 40'd0, 1'b0},
        '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, 40'd0, 1'b0},
        '{32'h2AAA_AAAA, 32'h5555_5555, 1'b1, 1'b0, 40'd0, 1'b0},
        '{32'h0001_0000, 32'h0000_0001, 1'b1, 1'b0, 40'd0, 1'b0},
        '{32'h8000_0001, PONE,          1'b1, 1'b1, 40'd0, 1'b0}
    };

    // run limit
    initial
    begin
        #15_000_000;
        $display("cross_entropy_loss_accumulator_core: mismatch");
        $finish;
    end

    // main sequence
    initial
    begin
        row_t r;
        for (int i = 0; i < TAB_N - 1; i++)
            mant_log[i] = mant_entry(i);
        mant_log[TAB_N - 1] = 64'd1 << 30;
        pm_mean = 1'b0;
        pm_count = 16'd1;
        pm_sum = '0;
        pm_clip = 1'b0;
        err_count = 0;
        idle_on = 1'b0;
        hold_on = 1'b0;
        out_stall = 1'b0;
        in_valid = 1'b0;
        probability = '0;
        target = '0;
        last = 1'b0;
        row_typed = 1'b0;
        row_loss = '0;
        row_sat = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_MEAN_MODE;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part, no idling
        foreach (directed[i])
            offer(directed[i]);
        quiesce();

        idle_on = 1'b1;
        random_phase(200, 1'b1);

        write_reg(REG_MEAN_MODE, 16'd1);
        write_reg(REG_MB_COUNT, 16'd3);
        random_phase(200, 1'b0);

        // zero divisor falls back to one
        write_reg(REG_MB_COUNT, 16'd0);
        random_phase(150, 1'b0);

        write_reg(REG_MB_COUNT, 16'd65535);
        random_phase(150, 1'b0);

        // spare index is ignored
        write_reg(REG_SPARE, 16'hFFFF);
        write_reg(REG_MB_COUNT, 16'd1);
        random_phase(150, 1'b0);

        write_reg(REG_MB_COUNT, 16'hA5C3);
        write_reg(REG_MEAN_MODE, 16'hFFFE);
        random_phase(150, 1'b0);

        // long back-to-back tensor at the floor with full target, largest terms
        idle_on = 1'b0;
        r.prob = '0;
        r.tgt = 32'hFFFF_FFFF;
        r.typed = 1'b0;
        r.loss = '0;
        r.sat = 1'b0;
        for (int i = 0; i < FLOOR_ITEMS; i++)
        begin
            r.lst = (i == FLOOR_ITEMS - 1);
            offer(r);
        end
        quiesce();

        if (err_count == 0)
            $display("cross_entropy_loss_accumulator_core: match");
        else
            $display("cross_entropy_loss_accumulator_core: mismatch");
        $finish;
    end

endmodule
